// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk, with synchronous rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// File: hdl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Types and constants shared by the packet deframer controller and datapath.
// ----------------------------------------------------------------------------
package cpd_pkg;

  // Payload buffer depth and derived widths
  localparam int MAX_PAYLOAD = 16;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_PAYLOAD);

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MARKER  = 2'd0;
  localparam logic [1:0] CFG_COMMAND_LIMIT = 2'd1;
  localparam logic [1:0] CFG_PAYLOAD_LIMIT = 2'd2;

  // Configuration reset values
  localparam logic [7:0] START_MARKER_RST  = 8'd60;
  localparam logic [8:0] COMMAND_LIMIT_RST = 9'd40;
  localparam logic [4:0] PAYLOAD_LIMIT_RST = 5'd16;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_PREP,
    ST_EMIT
  } cpd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_cmd;
    logic load_len;
    logic wr_en;
    logic clear;
    logic emit_load;
    logic idx_inc;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_hit;
    logic cmd_ok;
    logic len_ok;
    logic len_zero;
    logic frame_done;
    logic idx_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: hdl/cpd_ctrl.sv
// ----------------------------------------------------------------------------
// cpd_ctrl
// Frame parsing state machine: hunt, command, length, payload, drain.
// ----------------------------------------------------------------------------
module cpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpd_pkg::dp_status_t sts,
  output cpd_pkg::ctrl_cmd_t  cmd
);
  import cpd_pkg::*;

  `include "assert_macros.svh"

  cpd_state_t state;
  cpd_state_t state_next;
  logic       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state == ST_PREP) || (state == ST_EMIT);
    take       = in_valid && !in_stall;
    case (state)
      ST_HUNT: begin
        if (take && sts.start_hit) begin
          state_next = ST_CMD;
        end
      end
      ST_CMD: begin
        if (take) begin
          if (sts.cmd_ok) begin
            cmd.load_cmd = 1'b1;
            state_next   = ST_LEN;
          end else begin
            cmd.clear  = 1'b1;
            state_next = ST_HUNT;
          end
        end
      end
      ST_LEN: begin
        if (take) begin
          if (sts.len_ok) begin
            cmd.load_len = 1'b1;
            state_next   = ST_DATA;
          end else begin
            cmd.clear  = 1'b1;
            state_next = ST_HUNT;
          end
        end
      end
      ST_DATA: begin
        if (take) begin
          // an empty frame swallows one byte and stores nothing
          cmd.wr_en = !sts.len_zero;
          if (sts.len_zero || sts.frame_done) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        // wait for the buffer read of entry zero
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.idx_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_HUNT;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  `ASSERT_CLK(a_prep_to_emit, (state == ST_PREP) |=> (state == ST_EMIT))
  `ASSERT_CLK(a_last_ends_frame, (cmd.emit_load && sts.idx_last) |=> (state == ST_HUNT))
  `ASSERT_CLK(a_no_store_outside_data, cmd.wr_en |-> (state == ST_DATA))

endmodule

// File: hdl/cpd_dpath.sv
// ----------------------------------------------------------------------------
// cpd_dpath
// Configuration registers, frame header registers, payload buffer and the
// output register.
// ----------------------------------------------------------------------------
module cpd_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 rx_byte,
  input  logic                       cfg_valid,
  input  logic [1:0]                 cfg_index,
  input  logic [8:0]                 cfg_data,
  input  cpd_pkg::ctrl_cmd_t          cmd,
  output cpd_pkg::dp_status_t         sts,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [7:0]                 command_code,
  output logic [cpd_pkg::CNT_W-1:0]  payload_length,
  output logic [cpd_pkg::ADDR_W-1:0] byte_index,
  output logic [7:0]                 payload_byte,
  output logic                       last
);
  import cpd_pkg::*;

  `include "assert_macros.svh"

  logic [7:0]        start_marker;
  logic [8:0]        command_limit;
  logic [4:0]        payload_limit;
  logic [7:0]        held_command;
  logic [CNT_W-1:0]  expected_length;
  logic [CNT_W-1:0]  received_count;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] idx_next;
  logic [7:0]        rd_data;
  logic [7:0]        mem [MAX_PAYLOAD];

  // configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker  <= START_MARKER_RST;
      command_limit <= COMMAND_LIMIT_RST;
      payload_limit <= PAYLOAD_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_MARKER:  start_marker  <= cfg_data[7:0];
        CFG_COMMAND_LIMIT: command_limit <= cfg_data;
        CFG_PAYLOAD_LIMIT: payload_limit <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    idx_next = idx;
    if (cmd.clear || cmd.load_len) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_command    <= '0;
      expected_length <= '0;
      received_count  <= '0;
      idx             <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.clear) begin
        held_command    <= '0;
        expected_length <= '0;
        received_count  <= '0;
      end else begin
        if (cmd.load_cmd) begin
          held_command <= rx_byte;
        end
        if (cmd.load_len) begin
          expected_length <= CNT_W'(rx_byte);
          received_count  <= '0;
        end else if (cmd.wr_en) begin
          received_count <= received_count + CNT_W'(1);
        end
      end
    end
  end

  // payload buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[received_count[ADDR_W-1:0]] <= rx_byte;
    end
    rd_data <= mem[idx_next];
  end

  always_comb begin
    sts.start_hit  = (rx_byte == start_marker);
    sts.cmd_ok     = ({1'b0, rx_byte} < command_limit);
    sts.len_ok     = (rx_byte <= {3'b000, payload_limit}) && (rx_byte <= MAX_LEN_BYTE);
    sts.len_zero   = (expected_length == '0);
    sts.frame_done = ((received_count + CNT_W'(1)) >= expected_length);
    sts.idx_last   = sts.len_zero ||
                     ((CNT_W'(idx) + CNT_W'(1)) == expected_length);
    sts.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      command_code   <= held_command;
      payload_length <= expected_length;
      byte_index     <= idx;
      payload_byte   <= sts.len_zero ? 8'd0 : rd_data;
      last           <= sts.idx_last;
    end
  end

  `ASSERT_CLK(a_no_overwrite, cmd.emit_load |-> !(out_valid && out_stall))
  `ASSERT_CLK(a_store_in_range, cmd.wr_en |-> (received_count < expected_length))
  `ASSERT_CLK(a_idx_in_frame, cmd.emit_load |-> (sts.len_zero ||
              (CNT_W'(idx) < expected_length)))

endmodule

// File: hdl/command_packet_deframer.sv
// ----------------------------------------------------------------------------
// command_packet_deframer
// Start-byte, length-prefixed packet parser: buffers a frame's payload and
// replays it as one output word per payload byte (one zero word for an empty frame).
// ----------------------------------------------------------------------------
// Output: after the frame's last byte is taken, the PREP state reads buffer
//   entry zero and the EMIT state loads the first word into the output register.
// Throughput: one input byte per cycle while parsing; during drain the input
//   stalls and, while the output does not stall, one output word leaves per
//   cycle through the single read port of the payload buffer; an empty frame
//   still emits one zero word.
// Reset: rst (synchronous) returns to hunting, clears the header registers and
//   loads the register defaults; the payload buffer is not cleared.
module command_packet_deframer (
  input  logic                       clk,
  input  logic                       rst,
  // byte input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 rx_byte,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 command_code,
  output logic [cpd_pkg::CNT_W-1:0]  payload_length,
  output logic [cpd_pkg::ADDR_W-1:0] byte_index,
  output logic [7:0]                 payload_byte,
  output logic                       last,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [8:0]                 cfg_data
);
  import cpd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequence the frame phases and the drain of the buffer
  cpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold configuration, header, payload buffer and the output word
  cpd_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .command_code   (command_code),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .last           (last)
  );

endmodule
